@@ src/rsa_modular_exponentiation_core_assert.svh @@
// Assertion macros used by the checker file of the modexp core.
`ifndef RSA_MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define RSA_MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RMEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RMEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rsa_mexp_pkg.sv @@
// Shared types and codes of the RSA modular exponentiation core.
`default_nettype none
package rsa_mexp_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b1;

  // operations of the shared multiply-and-reduce unit
  typedef logic [1:0] op_t;
  localparam op_t OP_RED = 2'd0;  // base mod m (multiply by one)
  localparam op_t OP_MUL = 2'd1;  // acc = acc * base mod m
  localparam op_t OP_SQR = 2'd2;  // base = base * base mod m

  typedef struct packed {
    logic load;   // take a request word, start base reduction
    logic start;  // start an operation
    op_t  op;     // operation to start
    logic step;   // one shift-and-add step
    logic wb;     // last step: write the product to its destination
    logic emit;   // move the result to the output register
  } cmd_t;

  typedef struct packed {
    logic ebit;      // current exponent bit
    logic out_free;  // output register can take a result
  } sts_t;

endpackage
`default_nettype wire

@@ src/rsa_modular_exponentiation_core.sv @@
// Top level of the RSA modular exponentiation core (square-and-multiply, LSB first).
//
//   channel | dir | handshake               | payload
//   in_     | in  | in_tvalid / in_tready   | in_tdata : message_word
//   out_    | out | out_tvalid / out_tready | out_tdata: result_word
//   cfg_    | in  | cfg_wr_en               | cfg_addr, cfg_wr_data (exponent, modulus)
//
// One request at a time. The shift-and-add multiply-reduce unit takes one
// multiplier bit per cycle.
// rst_n is synchronous; exponent resets to 1, modulus to 2.
// A finished result waits in the output register; a new request is taken meanwhile.
`default_nettype none
module rsa_modular_exponentiation_core #(
  parameter int WORD_BITS = 31
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [((WORD_BITS+7)/8)*8-1:0]       in_tdata,    // message_word
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0]       out_tdata,   // result_word
  input  wire                                  cfg_wr_en,
  input  wire  [rsa_mexp_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire  [WORD_BITS-1:0]                 cfg_wr_data
);

  localparam int DATA_W = ((WORD_BITS + 7) / 8) * 8;

  rsa_mexp_pkg::cmd_t   cmd;
  rsa_mexp_pkg::sts_t   sts;
  logic [WORD_BITS-1:0] out_word;

  rsa_mexp_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsa_mexp_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_tdata[WORD_BITS-1:0]),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_word    (out_word)
  );

  assign out_tdata = DATA_W'(out_word);

endmodule
`default_nettype wire

@@ src/rsa_mexp_ctrl.sv @@
// Sequencer of the modexp core: bit loop and operation steps.
`default_nettype none
module rsa_mexp_ctrl #(
  parameter int WORD_BITS = 31
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  rsa_mexp_pkg::sts_t   sts,
  output rsa_mexp_pkg::cmd_t   cmd
);

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam int BIT_W = $clog2(WORD_BITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  rsa_mexp_pkg::op_t op_r, op_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BIT_W-1:0]  bits_r, bits_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    bits_nxt  = bits_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = rsa_mexp_pkg::OP_RED;
          cnt_nxt   = '0;
          bits_nxt  = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (cnt_r == CNT_W'(WORD_BITS - 1)) begin
          cmd.wb    = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_PICK;
          if (op_r == rsa_mexp_pkg::OP_SQR) begin
            bits_nxt = bits_r + BIT_W'(1);
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_PICK: begin
        if (op_r != rsa_mexp_pkg::OP_MUL && bits_r == BIT_W'(WORD_BITS)) begin
          state_nxt = S_DONE;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_RUN;
          // after a multiply the base is always squared
          if (op_r != rsa_mexp_pkg::OP_MUL && sts.ebit) begin
            cmd.op = rsa_mexp_pkg::OP_MUL;
          end else begin
            cmd.op = rsa_mexp_pkg::OP_SQR;
          end
          op_nxt = cmd.op;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= rsa_mexp_pkg::OP_RED;
      cnt_r   <= '0;
      bits_r  <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
      bits_r  <= bits_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/rsa_mexp_dp.sv @@
// Datapath of the modexp core: key registers, operands, shift-and-add unit, output register.
`default_nettype none
module rsa_mexp_dp #(
  parameter int WORD_BITS = 31
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  rsa_mexp_pkg::cmd_t                     cmd,
  output rsa_mexp_pkg::sts_t                     sts,
  input  wire                                    cfg_wr_en,
  input  wire  [rsa_mexp_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire  [WORD_BITS-1:0]                   cfg_wr_data,
  input  wire  [WORD_BITS-1:0]                   in_word,
  input  wire                                    out_ready,
  output logic                                   out_valid,
  output logic [WORD_BITS-1:0]                   out_word
);

  logic [WORD_BITS-1:0] exponent_r, modulus_r;
  logic [WORD_BITS-1:0] ebits_r;
  logic [WORD_BITS-1:0] base_r, acc_r, prod_r, ysh_r;
  rsa_mexp_pkg::op_t    op_r;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_word_r;

  logic [WORD_BITS:0]   dbl, mod_x, sum;
  logic [WORD_BITS-1:0] d1, xop, s1, t;
  logic                 mod_small;

  // one step: prod = 2*prod mod m, then + x mod m when the multiplier bit is set
  always_comb begin
    mod_x = {1'b0, modulus_r};
    dbl   = {prod_r, 1'b0};
    d1    = (dbl >= mod_x) ? WORD_BITS'(dbl - mod_x) : dbl[WORD_BITS-1:0];
    xop   = (op_r == rsa_mexp_pkg::OP_RED) ? WORD_BITS'(1) : base_r;
    sum   = {1'b0, d1} + {1'b0, xop};
    s1    = (sum >= mod_x) ? WORD_BITS'(sum - mod_x) : sum[WORD_BITS-1:0];
    t     = ysh_r[WORD_BITS-1] ? s1 : d1;
  end

  assign mod_small    = (modulus_r[WORD_BITS-1:1] == '0);
  assign sts.ebit     = ebits_r[0];
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= WORD_BITS'(1);
      modulus_r  <= WORD_BITS'(2);
    end else if (cfg_wr_en) begin
      if (cfg_addr == rsa_mexp_pkg::CFG_EXPONENT) begin
        exponent_r <= cfg_wr_data;
      end
      if (cfg_addr == rsa_mexp_pkg::CFG_MODULUS) begin
        modulus_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ysh_r   <= in_word;
      prod_r  <= '0;
      acc_r   <= WORD_BITS'(1);
      ebits_r <= exponent_r;
      op_r    <= rsa_mexp_pkg::OP_RED;
    end else if (cmd.start) begin
      prod_r <= '0;
      op_r   <= cmd.op;
      ysh_r  <= (cmd.op == rsa_mexp_pkg::OP_MUL) ? acc_r : base_r;
    end else if (cmd.step) begin
      prod_r <= t;
      ysh_r  <= {ysh_r[WORD_BITS-2:0], 1'b0};
      if (cmd.wb) begin
        if (op_r == rsa_mexp_pkg::OP_MUL) begin
          acc_r <= t;
        end else begin
          base_r <= t;
        end
        if (op_r == rsa_mexp_pkg::OP_SQR) begin
          ebits_r <= {1'b0, ebits_r[WORD_BITS-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // a modulus below two reduces everything to zero
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r <= mod_small ? '0 : acc_r;
    end
  end

endmodule
`default_nettype wire

@@ src/rsa_mexp_checker.sv @@
// Port-level checks of the modexp core and their bind.
`default_nettype none
`include "rsa_modular_exponentiation_core_assert.svh"
module rsa_mexp_checker #(
  parameter int WORD_BITS = 31
) (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [((WORD_BITS+7)/8)*8-1:0]   out_tdata
);

  `RMEC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `RMEC_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "stalled result changed")
  // the core works on one request at a time
  `RMEC_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "request taken while busy")
  // a result only appears at the end of a computation, never from idle
  `RMEC_ASSERT_NOW(a_result_from_busy, $rose(out_tvalid), $past(!in_tready), "result without work")

endmodule

bind rsa_modular_exponentiation_core rsa_mexp_checker #(.WORD_BITS(WORD_BITS)) u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
